// ===== hw/rtl/aff_pkg.sv =====
// shared constants, codes and types of the aligned first-fit allocator
package aff_pkg;

   localparam int MAX_LIVE_DEF  = 16;
   localparam int ADDR_BITS_DEF = 20;

   localparam int AMOUNT_W = 21;
   localparam int ALIGN_W  = 5;
   localparam int REGION_W = 21;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam logic [REGION_W-1:0] REGION_RESET = 21'd1048576;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

   typedef struct packed {
      logic                push;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  removed_count;
   } aff_resp_type;

endpackage

// ===== hw/rtl/aligned_first_fit_allocator_core.sv =====
// top level of the aligned first-fit allocator: config register, result register, sequencer
//
// usage
//   req_* channel: one transaction is an allocate or free command; it is taken when
//   req_valid is high and req_stall low. rsp_* channel returns exactly one result per
//   command, in order, taken when rsp_valid is high and rsp_stall low.
//   csr_* channel: writes region_size; csr_ready is always high, write only while idle.
// operation
//   one command at a time. free: one pass over the extent memory.
//   allocate: slot search over the valid bits, then per candidate one bound check plus
//   a pass through the extent memory; every overlap moves the candidate and costs
//   another pass, so the time grows with the live extents hit.
//   the single read port of the extent memory sets the pace, one entry per cycle.
// reset
//   clears all valid bits and the sequencer, region_size returns to 1048576.
// stalls
//   a result waits in the output register; the next command is still accepted and
//   worked on, and its result waits inside until the output register frees up.
module aligned_first_fit_allocator_core #(
   parameter int MAX_LIVE  = aff_pkg::MAX_LIVE_DEF,
   parameter int ADDR_BITS = aff_pkg::ADDR_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // command channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_command,
   input  logic [aff_pkg::AMOUNT_W-1:0]  req_amount,
   input  logic [aff_pkg::ALIGN_W-1:0]   req_align_log2,
   input  logic [ADDR_BITS-1:0]          req_free_address,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ADDR_BITS-1:0]          rsp_address,
   output logic [aff_pkg::STATUS_W-1:0]  rsp_status,
   output logic [aff_pkg::COUNT_W-1:0]   rsp_removed_count,
   // config write channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [aff_pkg::REGION_W-1:0]  csr_region_size
);
   import aff_pkg::*;

   logic [REGION_W-1:0]  region_ff;
   logic                 rsp_valid_ff;
   logic [ADDR_BITS-1:0] rsp_address_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;
   logic                 out_free;
   aff_resp_type         resp;
   logic [ADDR_BITS-1:0] resp_address;

   // output register can take a new result when empty or being drained
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   aff_ctrl #(
      .MAX_LIVE  (MAX_LIVE),
      .ADDR_BITS (ADDR_BITS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_amount       (req_amount),
      .req_align_log2   (req_align_log2),
      .req_free_address (req_free_address),
      .region_size      (region_ff),
      .out_free         (out_free),
      .resp             (resp),
      .resp_address     (resp_address)
   );

   // region size register
   always_ff @(posedge clock) begin
      if (reset) begin
         region_ff <= REGION_RESET;
      end else if (csr_valid && csr_ready) begin
         region_ff <= csr_region_size;
      end
   end

   // result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (resp.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload, loaded only when the slot is free so a stalled result holds
   always_ff @(posedge clock) begin
      if (resp.push) begin
         rsp_address_ff <= resp_address;
         rsp_status_ff  <= resp.status;
         rsp_count_ff   <= resp.removed_count;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_address       = rsp_address_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_count = rsp_count_ff;

endmodule

// ===== hw/rtl/aff_table.sv =====
// extent table memory: start and end per entry, one write and one registered read
module aff_table #(
   parameter int DEPTH = aff_pkg::MAX_LIVE_DEF,
   parameter int IDX_W = 4,
   parameter int AW    = aff_pkg::ADDR_BITS_DEF,
   parameter int EW    = 22
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [AW-1:0]    wr_start,
   input  logic [EW-1:0]    wr_end,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [AW-1:0]    rd_start,
   output logic [EW-1:0]    rd_end
);
   import aff_pkg::*;

   logic [AW+EW-1:0] mem [DEPTH];
   logic [AW+EW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_start, wr_end};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_start = rd_data_ff[AW+EW-1:EW];
   assign rd_end   = rd_data_ff[EW-1:0];

endmodule

// ===== hw/rtl/aff_ctrl.sv =====
// command sequencer: slot search, candidate check and table scans over the memory
module aff_ctrl #(
   parameter int MAX_LIVE  = aff_pkg::MAX_LIVE_DEF,
   parameter int ADDR_BITS = aff_pkg::ADDR_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_command,
   input  logic [aff_pkg::AMOUNT_W-1:0]  req_amount,
   input  logic [aff_pkg::ALIGN_W-1:0]   req_align_log2,
   input  logic [ADDR_BITS-1:0]          req_free_address,
   input  logic [aff_pkg::REGION_W-1:0]  region_size,
   input  logic                          out_free,
   output aff_pkg::aff_resp_type         resp,
   output logic [ADDR_BITS-1:0]          resp_address
);
   import aff_pkg::*;

   localparam int IDX_W = (MAX_LIVE > 1) ? $clog2(MAX_LIVE) : 1;
   localparam int CNT_W = $clog2(MAX_LIVE + 1);
   localparam int EW    = ((ADDR_BITS > AMOUNT_W) ? ADDR_BITS : AMOUNT_W) + 1;
   localparam int CW    = ((EW > 32) ? EW : 32) + 1;
   localparam logic [IDX_W-1:0] LAST = IDX_W'(MAX_LIVE - 1);
   localparam logic [CW-1:0]    CAP  = CW'(1) << ADDR_BITS;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FIND  = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic                 cmd_ff, cmd_in;
   logic [AMOUNT_W-1:0]  amount_ff, amount_in;
   logic [CW-1:0]        mask_ff, mask_in;
   logic [CW-1:0]        region_ff, region_in;
   logic [ADDR_BITS-1:0] free_addr_ff, free_addr_in;
   logic [IDX_W-1:0]     slot_ff, slot_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 iss_ff, iss_in;
   logic                 pend_ff, pend_in;
   logic [IDX_W-1:0]     pidx_ff, pidx_in;
   logic                 plast_ff, plast_in;
   logic [CW-1:0]        c_ff, c_in;
   logic [CW-1:0]        c_end_ff, c_end_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [ADDR_BITS-1:0] res_addr_ff, res_addr_in;
   logic [MAX_LIVE-1:0]  valid_ff, valid_in;

   logic                 wr_en;
   logic                 rd_en;
   logic [ADDR_BITS-1:0] rd_start;
   logic [EW-1:0]        rd_end;
   logic [CW-1:0]        start_ext;
   logic [CW-1:0]        end_ext;
   logic [CW-1:0]        region_ext;
   logic [CW-1:0]        c_sum;
   logic                 entry_live;
   logic                 hit;
   logic                 match;

   aff_table #(
      .DEPTH (MAX_LIVE),
      .IDX_W (IDX_W),
      .AW    (ADDR_BITS),
      .EW    (EW)
   ) u_table (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (slot_ff),
      .wr_start (c_ff[ADDR_BITS-1:0]),
      .wr_end   (c_end_ff[EW-1:0]),
      .rd_en    (rd_en),
      .rd_addr  (idx_ff),
      .rd_start (rd_start),
      .rd_end   (rd_end)
   );

   assign start_ext  = CW'(rd_start);
   assign end_ext    = CW'(rd_end);
   assign region_ext = CW'(region_size);
   assign c_sum      = c_ff + CW'(amount_ff);
   assign entry_live = valid_ff[pidx_ff];
   assign hit        = entry_live && (start_ext < c_end_ff) && (c_ff < end_ext);
   assign match      = entry_live && (rd_start == free_addr_ff);

   assign req_stall          = (state_ff != S_IDLE);
   assign rd_en              = (state_ff == S_SCAN) && iss_ff;
   assign resp.push          = (state_ff == S_DONE) && out_free;
   assign resp.status        = status_ff;
   assign resp.removed_count = COUNT_W'(count_ff);
   assign resp_address       = res_addr_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      amount_in    = amount_ff;
      mask_in      = mask_ff;
      region_in    = region_ff;
      free_addr_in = free_addr_ff;
      slot_in      = slot_ff;
      idx_in       = idx_ff;
      iss_in       = iss_ff;
      pend_in      = 1'b0;
      pidx_in      = pidx_ff;
      plast_in     = plast_ff;
      c_in         = c_ff;
      c_end_in     = c_end_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      res_addr_in  = res_addr_ff;
      valid_in     = valid_ff;
      wr_en        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in       = req_command;
               amount_in    = req_amount;
               mask_in      = (CW'(1) << req_align_log2) - CW'(1);
               region_in    = (region_ext > CAP) ? CAP : region_ext;
               free_addr_in = req_free_address;
               idx_in       = '0;
               count_in     = '0;
               status_in    = ST_DONE;
               res_addr_in  = '0;
               if (req_command == CMD_FREE) begin
                  iss_in   = 1'b1;
                  state_in = S_SCAN;
               end else begin
                  state_in = S_FIND;
               end
            end
         end
         S_FIND: begin
            // lowest free slot, one valid bit a cycle
            if (!valid_ff[idx_ff]) begin
               slot_in  = idx_ff;
               c_in     = '0;
               state_in = S_CHECK;
            end else if (idx_ff == LAST) begin
               status_in = ST_FULL;
               state_in  = S_DONE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_CHECK: begin
            if ((c_sum > region_ff) || (c_ff >= CAP)) begin
               status_in = ST_NO_SPACE;
               state_in  = S_DONE;
            end else begin
               c_end_in = c_sum;
               idx_in   = '0;
               iss_in   = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (iss_ff) begin
               pend_in  = 1'b1;
               pidx_in  = idx_ff;
               plast_in = (idx_ff == LAST);
               if (idx_ff == LAST) begin
                  iss_in = 1'b0;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
            if (pend_ff) begin
               if (cmd_ff == CMD_FREE) begin
                  if (match) begin
                     valid_in[pidx_ff] = 1'b0;
                     count_in          = count_ff + CNT_W'(1);
                  end
                  if (plast_ff) begin
                     state_in = S_DONE;
                  end
               end else if (hit) begin
                  // skip past the overlapped entry and start a new pass
                  c_in     = (end_ext + mask_ff) & ~mask_ff;
                  iss_in   = 1'b0;
                  pend_in  = 1'b0;
                  state_in = S_CHECK;
               end else if (plast_ff) begin
                  wr_en             = 1'b1;
                  valid_in[slot_ff] = 1'b1;
                  res_addr_in       = c_ff[ADDR_BITS-1:0];
                  state_in          = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         iss_ff   <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         iss_ff   <= iss_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      amount_ff    <= amount_in;
      mask_ff      <= mask_in;
      region_ff    <= region_in;
      free_addr_ff <= free_addr_in;
      slot_ff      <= slot_in;
      idx_ff       <= idx_in;
      pidx_ff      <= pidx_in;
      plast_ff     <= plast_in;
      c_ff         <= c_in;
      c_end_ff     <= c_end_in;
      count_ff     <= count_in;
      status_ff    <= status_in;
      res_addr_ff  <= res_addr_in;
   end

endmodule

// ===== bench/tb_aligned_first_fit_allocator_core.sv =====
// self-checking testbench of the aligned first-fit allocator core
module tb_aligned_first_fit_allocator_core;
   timeunit 1ns;
   timeprecision 1ps;

   import aff_pkg::*;

   localparam int MAX_LIVE  = MAX_LIVE_DEF;
   localparam int ADDR_BITS = ADDR_BITS_DEF;
   localparam bit [63:0] ADDR_CAP = 64'd1 << ADDR_BITS;

   // one command as it sits on the req_ ports
   typedef struct packed {
      logic                  command;
      logic [AMOUNT_W-1:0]   amount;
      logic [ALIGN_W-1:0]    align_log2;
      logic [ADDR_BITS-1:0]  free_address;
   } cmd_item_type;

   // one result as it sits on the rsp_ ports
   typedef struct packed {
      logic [ADDR_BITS-1:0]  address;
      logic [STATUS_W-1:0]   status;
      logic [COUNT_W-1:0]    removed_count;
   } outcome_type;

   // clock, reset and every block input start at known values
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_command = CMD_ALLOC;
   logic [AMOUNT_W-1:0]   req_amount = '0;
   logic [ALIGN_W-1:0]    req_align_log2 = '0;
   logic [ADDR_BITS-1:0]  req_free_address = '0;

   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [ADDR_BITS-1:0]  rsp_address;
   logic [STATUS_W-1:0]   rsp_status;
   logic [COUNT_W-1:0]    rsp_removed_count;

   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [REGION_W-1:0]   csr_region_size = REGION_RESET;

   aligned_first_fit_allocator_core #(
      .MAX_LIVE  (MAX_LIVE),
      .ADDR_BITS (ADDR_BITS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_amount        (req_amount),
      .req_align_log2    (req_align_log2),
      .req_free_address  (req_free_address),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_address       (rsp_address),
      .rsp_status        (rsp_status),
      .rsp_removed_count (rsp_removed_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_region_size   (csr_region_size)
   );

   // 8 ns clock
   initial begin
      forever #4 clock = ~clock;
   end

   // synchronous reset held from the start, released once
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // ------------------------------------------------------------------
   // shadow copy of the allocator: region register and the extent table
   // ------------------------------------------------------------------
   logic [REGION_W-1:0]   region_reg = REGION_RESET;
   logic [ADDR_BITS-1:0]  ent_start [MAX_LIVE];
   logic [AMOUNT_W-1:0]   ent_size  [MAX_LIVE];
   bit                    ent_live  [MAX_LIVE] = '{default: 1'b0};

   cmd_item_type cmd_backlog [$];       // commands waiting for the driver
   outcome_type  pending_outcomes [$];  // results owed by the block, oldest first

   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int n_accepted = 0;
   int n_checked = 0;
   int mismatches = 0;
   int n_granted = 0;
   int n_no_space = 0;
   int n_full = 0;
   int n_released = 0;
   int n_settings = 1;

   // updates the shadow table for one command and returns the result it must produce
   function automatic outcome_type grant_or_release(input cmd_item_type it);
      outcome_type o;
      bit [63:0]   region;
      bit [63:0]   align;
      bit [63:0]   cand;
      bit [63:0]   top;
      int          slot;
      bit          hit;
      bit          found;
      bit          done;
      o = '0;
      o.status = ST_DONE;
      if (it.command == CMD_FREE) begin
         // every live extent with a matching start goes, duplicates included
         for (int i = 0; i < MAX_LIVE; i++) begin
            if (ent_live[i] && ent_start[i] == it.free_address) begin
               ent_live[i] = 1'b0;
               o.removed_count = o.removed_count + 1'b1;
               n_released++;
            end
         end
      end else begin
         // register values past the address space behave as the full space
         region = (64'(region_reg) < ADDR_CAP) ? 64'(region_reg) : ADDR_CAP;
         align = 64'd1 << it.align_log2;
         slot = -1;
         for (int i = MAX_LIVE - 1; i >= 0; i--) begin
            if (!ent_live[i]) slot = i;
         end
         if (slot < 0) begin
            // table full: no search at all
            o.status = ST_FULL;
            n_full++;
         end else begin
            cand = '0;
            found = 1'b0;
            done = 1'b0;
            while (!done) begin
               // out of region, or a zero-size candidate beyond the address space
               if (cand + it.amount > region || cand >= ADDR_CAP) begin
                  done = 1'b1;
               end else begin
                  hit = 1'b0;
                  for (int i = 0; i < MAX_LIVE && !hit; i++) begin
                     if (ent_live[i] && 64'(ent_start[i]) < cand + it.amount &&
                         cand < 64'(ent_start[i]) + 64'(ent_size[i])) begin
                        // all candidates below the end of this extent collide with it
                        top = 64'(ent_start[i]) + 64'(ent_size[i]);
                        cand = (top + align - 64'd1) & ~(align - 64'd1);
                        hit = 1'b1;
                     end
                  end
                  if (!hit) begin
                     found = 1'b1;
                     done = 1'b1;
                  end
               end
            end
            if (found) begin
               ent_start[slot] = cand[ADDR_BITS-1:0];
               ent_size[slot] = it.amount;
               ent_live[slot] = 1'b1;
               o.address = cand[ADDR_BITS-1:0];
               n_granted++;
            end else begin
               o.status = ST_NO_SPACE;
               n_no_space++;
            end
         end
      end
      return o;
   endfunction

   // unused fields carry random bits so that every port bit toggles
   function automatic void queue_alloc(input logic [AMOUNT_W-1:0] amt,
                                       input logic [ALIGN_W-1:0] aln);
      cmd_item_type it;
      it.command = CMD_ALLOC;
      it.amount = amt;
      it.align_log2 = aln;
      it.free_address = ADDR_BITS'($urandom());
      cmd_backlog = {cmd_backlog, it};
   endfunction

   function automatic void queue_free(input logic [ADDR_BITS-1:0] addr);
      cmd_item_type it;
      it.command = CMD_FREE;
      it.amount = AMOUNT_W'($urandom());
      it.align_log2 = ALIGN_W'($urandom());
      it.free_address = addr;
      cmd_backlog = {cmd_backlog, it};
   endfunction

   // ------------------------------------------------------------------
   // command driver: holds each transaction until the block takes it
   // ------------------------------------------------------------------
   int           req_gap = 0;
   cmd_item_type drv_item;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         // transaction taken on this edge: predict now, maybe idle afterwards
         if (req_valid && !req_stall) begin
            pending_outcomes = {pending_outcomes, grant_or_release(drv_item)};
            n_accepted++;
            if (req_idle_pct > 0 && $urandom_range(99) < req_idle_pct)
               req_gap = $urandom_range(19, 1);
         end
         // a stalled command stays on the ports untouched
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (cmd_backlog.size() != 0) begin
               drv_item = cmd_backlog.pop_front();
               req_valid <= 1'b1;
               req_command <= drv_item.command;
               req_amount <= drv_item.amount;
               req_align_log2 <= drv_item.align_log2;
               req_free_address <= drv_item.free_address;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // result monitor: checks every result against the oldest prediction
   // and throws in bursts of backpressure
   // ------------------------------------------------------------------
   int rsp_hold = 0;

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            n_checked++;
            if (pending_outcomes.size() == 0) begin
               // result that no command asked for
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected result addr %h status %0d removed %0d",
                           $realtime, rsp_address, rsp_status, rsp_removed_count);
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_address !== want.address || rsp_status !== want.status ||
                   rsp_removed_count !== want.removed_count) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"%0t: result %0d expected addr %h status %0d removed %0d,",
                               " got addr %h status %0d removed %0d"},
                              $realtime, n_checked, want.address, want.status,
                              want.removed_count, rsp_address, rsp_status,
                              rsp_removed_count);
               end
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_stall <= 1'b1;
         end else if (rsp_idle_pct > 0 && $urandom_range(99) < rsp_idle_pct) begin
            // start a burst of stalled cycles, this one included, its length drawn at random
            rsp_hold = $urandom_range(18, 0);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------

   // block idle: nothing queued, nothing on the ports, nothing owed
   task automatic settle();
      while (cmd_backlog.size() != 0 || req_valid || pending_outcomes.size() != 0)
         @(negedge clock);
   endtask

   // region register write, only ever issued from an idle block
   task automatic write_region(input logic [REGION_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_region_size <= value;
      do @(posedge clock); while (!csr_ready);
      region_reg = value;
      n_settings++;
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // random traffic; frees mostly aim at live extents so the table churns
   task automatic run_phase(input int n_items, input int req_pct, input int rsp_pct);
      int                   live_idx [$];
      bit [63:0]            r;
      int                   lim;
      int                   pick;
      int                   free_pct;
      logic [AMOUNT_W-1:0]  amt;
      logic [ALIGN_W-1:0]   aln;
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      repeat (n_items) begin
         // keep the backlog short so the generator sees a fresh table
         while (cmd_backlog.size() >= 2) @(negedge clock);
         live_idx.delete();
         for (int i = 0; i < MAX_LIVE; i++) begin
            if (ent_live[i]) live_idx = {live_idx, i};
         end
         r = (64'(region_reg) < ADDR_CAP) ? 64'(region_reg) : ADDR_CAP;
         // lean toward frees when the table is close to full
         free_pct = (live_idx.size() >= MAX_LIVE - 2) ? 65 : 35;
         if ($urandom_range(99) < free_pct) begin
            pick = $urandom_range(99);
            if (pick < 75 && live_idx.size() != 0)
               queue_free(ent_start[live_idx[$urandom_range(live_idx.size() - 1)]]);
            else if (pick < 90)
               queue_free(ADDR_BITS'($urandom()));
            else
               queue_free('0);
         end else begin
            lim = (r > 64'd32) ? int'(r / 64'd16) : 2;
            pick = $urandom_range(99);
            if (pick < 5)
               amt = '0;
            else if (pick < 60)
               amt = AMOUNT_W'($urandom_range(lim, 1));
            else if (pick < 85)
               amt = AMOUNT_W'($urandom_range(int'(r), 0));
            else if (pick < 93)
               amt = AMOUNT_W'($urandom());
            else
               amt = AMOUNT_W'(r + 64'($urandom_range(2, 0)) - 64'd1);   // region edge
            pick = $urandom_range(99);
            if (pick < 70)
               aln = ALIGN_W'($urandom_range(6, 0));
            else if (pick < 90)
               aln = ALIGN_W'($urandom_range(19, 0));
            else
               aln = ALIGN_W'($urandom_range(31, 0));
            queue_alloc(amt, aln);
         end
      end
      settle();
   endtask

   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);

      // directed part, region at its reset value of 1 MiB
      req_idle_pct = 10;
      rsp_idle_pct = 10;
      queue_alloc(21'd0, 5'd0);               // zero-size extent at 0
      queue_alloc(21'd16, 5'd4);              // zero-size extent does not block 0
      queue_alloc(21'd1048576, 5'd0);         // whole region, blocked by the extent at 0
      queue_alloc('1, '1);                    // amount beyond region, widest alignment
      queue_alloc(21'd100, 5'd19);            // largest legal alignment, lands at 512 KiB
      queue_alloc(21'd5, 5'd31);              // alignment past the region leaves only 0
      repeat (13) queue_alloc(21'd1, 5'd0);   // fill every slot
      queue_alloc(21'd8, 5'd3);               // table full
      queue_free(20'd0);                      // releases both extents starting at 0
      queue_free('1);                         // address nobody holds
      queue_free(20'd524288);
      settle();

      run_phase(300, 15, 15);
      write_region(21'd4096);
      run_phase(250, 30, 10);
      write_region('0);                  // empty region: only zero-size at 0 fits
      run_phase(60, 0, 40);
      write_region(21'd1);
      run_phase(60, 10, 0);
      write_region('1);                  // above the address space, clipped
      run_phase(200, 20, 20);
      write_region(21'd300);
      run_phase(150, 40, 30);
      // final stretch at full speed on both sides
      write_region(REGION_RESET);
      run_phase(180, 0, 0);

      // a free pass plus margin to catch a stray result
      repeat (2 * MAX_LIVE + 8) @(posedge clock);

      $display("%0d commands over %0d region settings, %0d results checked, %0d mismatches",
               n_accepted, n_settings, n_checked, mismatches);
      $display("grants %0d, no-space %0d, table-full %0d, extents released %0d",
               n_granted, n_no_space, n_full, n_released);
      if (mismatches == 0 && pending_outcomes.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // watchdog far beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("timeout with %0d results outstanding", pending_outcomes.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule
